// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker files; the port checker uses them.
// Each macro expands to one labelled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, switched off while reset is high.
`define LQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define LQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/lqbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Link quality bucket statistics: shared package
// Field widths, register indexes, reset values and the types that pass
// between the front end, the back end and the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lqbs_pkg;

   localparam int CFG_W      = 12;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam int STR_W      = 8;
   localparam int SLOT_W     = 6;
   localparam int CNT_W      = 12;
   localparam int SUM_W      = 20;
   localparam int TOT_W      = 32;
   localparam int PCT_W      = 7;
   localparam int ECNT_W     = 8;
   localparam int DIV_W      = 20;
   localparam int DVS_W      = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET   = 4'd1;

   localparam logic [CFG_W-1:0] INTERVAL_RST = 12'd10;
   localparam logic [CFG_W-1:0] BUCKET_RST   = 12'd60;

   localparam logic MODE_READ = 1'b1;

   localparam logic [PCT_W-1:0]  PCT_SCALE = 7'd100;
   localparam logic [ECNT_W-1:0] COUNT_MAX = 8'd255;

   typedef struct packed {
      logic                    valid;
      logic signed [STR_W-1:0] avg;
      logic [PCT_W-1:0]        pct;
      logic [ECNT_W-1:0]       cnt;
   } hist_entry_type;

   typedef struct packed {
      logic                    is_read;
      logic                    link_up;
      logic                    counts_strength;
      logic signed [STR_W-1:0] strength;
      logic [SLOT_W-1:0]       read_slot;
   } queue_item_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// ----- rtl/link_quality_bucket_stats_unit.sv -----
// ----------------------------------------------------------------------------
// Link quality bucket statistics unit
//   req_* carries one item per beat: a sample (req_mode 0) adds to the
//   connected or disconnected seconds total and to the open bucket; a read
//   (req_mode 1) returns history entry req_read_slot. rsp_* returns exactly
//   one result beat per item, in order.
//   csr_* writes interval_seconds (index 0) or the bucket length in samples
//   (index 1); other indexes are dropped. Write only while no item is in flight.
//   Items are carried out one at a time. A sample that closes a bucket runs
//   the shared 20-step divider for the average and then the percentage; the
//   average division is skipped (average 0) if the bucket holds no strength
//   sample. The next queued item starts once a result is loaded; a two-entry
//   queue behind req_* takes further items meanwhile.
//   After reset the history ring is wiped, one entry per cycle, all
//   HISTORY_DEPTH entries; req_stall stays high meanwhile (csr_* still taken).
//   While rsp_stall is high the result is held and the unit finishes the
//   next item up to its response, then waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module link_quality_bucket_stats_unit #(
   parameter int HISTORY_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic               req_link_up,
   input  logic signed [7:0]  req_strength_dbm,
   input  logic [5:0]         req_read_slot,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [7:0]  rsp_recent_strength,
   output logic               rsp_recent_link_up,
   output logic [31:0]        rsp_up_seconds,
   output logic [31:0]        rsp_down_seconds,
   output logic [5:0]         rsp_slot_now,
   output logic               rsp_bucket_closed,
   output logic               rsp_entry_valid,
   output logic signed [7:0]  rsp_entry_avg_strength,
   output logic [6:0]         rsp_entry_up_percent,
   output logic [7:0]         rsp_entry_count,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import lqbs_pkg::*;

   queue_item_type q_item;
   logic           q_valid;
   logic           q_pop;
   logic           clear_busy;
   div_req_type    div_req;
   div_rsp_type    div_rsp;

   lqbs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_link_up      (req_link_up),
      .req_strength_dbm (req_strength_dbm),
      .req_read_slot    (req_read_slot),
      .clear_busy       (clear_busy),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   lqbs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   lqbs_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .q_valid                (q_valid),
      .q_item                 (q_item),
      .q_pop                  (q_pop),
      .clear_busy             (clear_busy),
      .div_req                (div_req),
      .div_rsp                (div_rsp),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_recent_strength    (rsp_recent_strength),
      .rsp_recent_link_up     (rsp_recent_link_up),
      .rsp_up_seconds         (rsp_up_seconds),
      .rsp_down_seconds       (rsp_down_seconds),
      .rsp_slot_now           (rsp_slot_now),
      .rsp_bucket_closed      (rsp_bucket_closed),
      .rsp_entry_valid        (rsp_entry_valid),
      .rsp_entry_avg_strength (rsp_entry_avg_strength),
      .rsp_entry_up_percent   (rsp_entry_up_percent),
      .rsp_entry_count        (rsp_entry_count)
   );

endmodule

`default_nettype wire

// ----- rtl/lqbs_front.sv -----
// ----------------------------------------------------------------------------
// Link quality bucket statistics: front end
// Takes request beats, classifies them as sample or read, works out the
// recorded strength and queues them for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lqbs_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_mode,
   input  logic                       req_link_up,
   input  logic signed [7:0]          req_strength_dbm,
   input  logic [5:0]                 req_read_slot,
   input  logic                       clear_busy,
   output logic                       q_valid,
   output lqbs_pkg::queue_item_type   q_item,
   input  logic                       q_pop
);
   import lqbs_pkg::*;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);

   queue_item_type         slot_ff [QDEPTH];
   queue_item_type         item_in;
   logic [QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]        count_ff, count_in;
   logic                   push;

   // hold off while the history store is being wiped or the queue is full
   assign req_stall = clear_busy || (count_ff == (QPTR_W+1)'(QDEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      item_in.is_read         = (req_mode == MODE_READ);
      item_in.link_up         = req_link_up;
      item_in.strength        = req_link_up ? req_strength_dbm : '0;
      item_in.counts_strength = req_link_up && (req_strength_dbm != '0);
      item_in.read_slot       = req_read_slot;
   end

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, q_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/lqbs_div.sv -----
// ----------------------------------------------------------------------------
// Link quality bucket statistics: iterative divider
// Unsigned restoring division, one quotient bit per cycle, shared by the
// average and the percentage calculations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lqbs_div (
   input  logic                  clock,
   input  logic                  reset,
   input  lqbs_pkg::div_req_type div_req,
   output lqbs_pkg::div_rsp_type div_rsp
);
   import lqbs_pkg::*;

   localparam int STEP_W = $clog2(DIV_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_W - 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [DIV_W-1:0]   dvd_ff, dvd_in;
   logic [DVS_W-1:0]   dvs_ff, dvs_in;
   logic [DVS_W:0]     rem_ff, rem_in;
   logic [DVS_W:0]     rem_sh;
   logic               fits;

   assign rem_sh = {rem_ff[DVS_W-1:0], dvd_ff[DIV_W-1]};
   assign fits   = (rem_sh >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (busy_ff) begin
         // shift in the next dividend bit, quotient bits fill from the bottom
         rem_in  = fits ? rem_sh - {1'b0, dvs_ff} : rem_sh;
         dvd_in  = {dvd_ff[DIV_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         rem_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvd_ff;

endmodule

`default_nettype wire

// ----- rtl/lqbs_back.sv -----
// ----------------------------------------------------------------------------
// Link quality bucket statistics: back end
// Holds the totals, the open bucket and the history ring, carries out one
// queued item at a time and loads the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lqbs_back #(
   parameter int HISTORY_DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [3:0]               csr_index,
   input  logic [15:0]              csr_wdata,
   input  logic                     q_valid,
   input  lqbs_pkg::queue_item_type q_item,
   output logic                     q_pop,
   output logic                     clear_busy,
   output lqbs_pkg::div_req_type    div_req,
   input  lqbs_pkg::div_rsp_type    div_rsp,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [7:0]        rsp_recent_strength,
   output logic                     rsp_recent_link_up,
   output logic [31:0]              rsp_up_seconds,
   output logic [31:0]              rsp_down_seconds,
   output logic [5:0]               rsp_slot_now,
   output logic                     rsp_bucket_closed,
   output logic                     rsp_entry_valid,
   output logic signed [7:0]        rsp_entry_avg_strength,
   output logic [6:0]               rsp_entry_up_percent,
   output logic [7:0]               rsp_entry_count
);
   import lqbs_pkg::*;

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int XW = (AW > SLOT_W) ? AW : SLOT_W;
   localparam logic [AW-1:0] SLOT_LAST = AW'(HISTORY_DEPTH - 1);

   localparam logic [3:0] ST_CLEAR    = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_READ     = 4'd2;
   localparam logic [3:0] ST_AVG_GO   = 4'd3;
   localparam logic [3:0] ST_AVG_WAIT = 4'd4;
   localparam logic [3:0] ST_PCT_GO   = 4'd5;
   localparam logic [3:0] ST_PCT_WAIT = 4'd6;
   localparam logic [3:0] ST_WRITE    = 4'd7;
   localparam logic [3:0] ST_WIPE     = 4'd8;
   localparam logic [3:0] ST_OUT      = 4'd9;

   logic [3:0]              state_ff, state_in;
   logic [AW-1:0]           clr_ff, clr_in;
   logic [CFG_W-1:0]        interval_ff, interval_in;
   logic [CFG_W-1:0]        spb_ff, spb_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]        ss_ff, ss_in;
   logic [CNT_W-1:0]        ups_ff, ups_in;
   logic [CNT_W-1:0]        all_ff, all_in;
   logic [AW-1:0]           fill_ff, fill_in;
   logic [TOT_W-1:0]        up_tot_ff, up_tot_in;
   logic [TOT_W-1:0]        dn_tot_ff, dn_tot_in;
   logic signed [STR_W-1:0] last_str_ff, last_str_in;
   logic                    last_up_ff, last_up_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic signed [STR_W-1:0] avg_ff, avg_in;
   logic [PCT_W-1:0]        pct_ff, pct_in;
   hist_entry_type          ent_ff, ent_in;
   logic                    closed_ff, closed_in;
   logic                    in_range_ff, in_range_in;
   hist_entry_type          rd_data_ff;
   logic                    load_rsp;

   hist_entry_type          mem [HISTORY_DEPTH];
   logic                    mem_we;
   logic [AW-1:0]           mem_wa;
   hist_entry_type          mem_wd;
   logic [AW-1:0]           rd_addr;
   logic [XW-1:0]           rd_x;
   logic [XW-1:0]           fill_x;

   logic [CNT_W-1:0]        all_next;
   logic [DIV_W-1:0]        sum_mag;
   logic [DIV_W-1:0]        pct_num;
   logic [STR_W-1:0]        quo8;
   hist_entry_type          new_ent;

   assign csr_ready  = 1'b1;
   assign clear_busy = (state_ff == ST_CLEAR);

   assign rd_x    = XW'(q_item.read_slot);
   assign rd_addr = rd_x[AW-1:0];
   assign fill_x  = XW'(fill_ff);

   assign all_next = all_ff + 1'b1;
   assign sum_mag  = sum_ff[SUM_W-1] ? DIV_W'(-sum_ff) : DIV_W'(sum_ff);
   assign pct_num  = DIV_W'(ups_ff) * DIV_W'(PCT_SCALE);
   assign quo8     = div_rsp.quotient[STR_W-1:0];

   always_comb begin
      new_ent.valid = (all_ff != '0);
      new_ent.avg   = avg_ff;
      new_ent.pct   = pct_ff;
      new_ent.cnt   = (ss_ff > CNT_W'(COUNT_MAX)) ? COUNT_MAX : ss_ff[ECNT_W-1:0];
   end

   // history ring: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      interval_in = interval_ff;
      spb_in      = spb_ff;
      sum_in      = sum_ff;
      ss_in       = ss_ff;
      ups_in      = ups_ff;
      all_in      = all_ff;
      fill_in     = fill_ff;
      up_tot_in   = up_tot_ff;
      dn_tot_in   = dn_tot_ff;
      last_str_in = last_str_ff;
      last_up_in  = last_up_ff;
      avg_in      = avg_ff;
      pct_in      = pct_ff;
      ent_in      = ent_ff;
      closed_in   = closed_ff;
      in_range_in = in_range_ff;
      q_pop       = 1'b0;
      load_rsp    = 1'b0;
      mem_we      = 1'b0;
      mem_wa      = fill_ff;
      mem_wd      = '0;

      div_req.start    = 1'b0;
      div_req.dividend = (state_ff == ST_AVG_GO) ? sum_mag : pct_num;
      div_req.divisor  = (state_ff == ST_AVG_GO) ? ss_ff : all_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_INTERVAL: interval_in = csr_wdata[CFG_W-1:0];
            CSR_BUCKET:   spb_in      = csr_wdata[CFG_W-1:0];
            default:      ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SLOT_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.is_read) begin
                  in_range_in = (32'(q_item.read_slot) < 32'(HISTORY_DEPTH));
                  state_in    = ST_READ;
               end else begin
                  if (q_item.link_up) begin
                     up_tot_in = up_tot_ff + TOT_W'(interval_ff);
                     ups_in    = ups_ff + 1'b1;
                  end else begin
                     dn_tot_in = dn_tot_ff + TOT_W'(interval_ff);
                  end
                  last_str_in = q_item.strength;
                  last_up_in  = q_item.link_up;
                  if (q_item.counts_strength) begin
                     sum_in = sum_ff + {{(SUM_W-STR_W){q_item.strength[STR_W-1]}},
                                        q_item.strength};
                     ss_in  = ss_ff + 1'b1;
                  end
                  all_in = all_next;
                  if (all_next >= spb_ff) begin
                     closed_in = 1'b1;
                     state_in  = ST_AVG_GO;
                  end else begin
                     closed_in = 1'b0;
                     ent_in    = '0;
                     state_in  = ST_OUT;
                  end
               end
            end
         end
         ST_READ: begin
            closed_in = 1'b0;
            ent_in    = in_range_ff ? rd_data_ff : '0;
            state_in  = ST_OUT;
         end
         ST_AVG_GO: begin
            if (ss_ff != '0) begin
               div_req.start = 1'b1;
               state_in      = ST_AVG_WAIT;
            end else begin
               avg_in   = '0;
               state_in = ST_PCT_GO;
            end
         end
         ST_AVG_WAIT: begin
            if (div_rsp.done) begin
               // truncate toward zero: divide magnitudes, restore the sign
               avg_in   = sum_ff[SUM_W-1] ? (~quo8 + 1'b1) : quo8;
               state_in = ST_PCT_GO;
            end
         end
         ST_PCT_GO: begin
            if (all_ff != '0) begin
               div_req.start = 1'b1;
               state_in      = ST_PCT_WAIT;
            end else begin
               pct_in   = '0;
               state_in = ST_WRITE;
            end
         end
         ST_PCT_WAIT: begin
            if (div_rsp.done) begin
               pct_in   = div_rsp.quotient[PCT_W-1:0];
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            mem_we   = 1'b1;
            mem_wd   = new_ent;
            ent_in   = new_ent;
            fill_in  = (fill_ff == SLOT_LAST) ? '0 : fill_ff + 1'b1;
            sum_in   = '0;
            ss_in    = '0;
            ups_in   = '0;
            all_in   = '0;
            state_in = ST_WIPE;
         end
         ST_WIPE: begin
            // clear the entry the next bucket will fill
            mem_we   = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = (rsp_valid_ff && rsp_stall) || load_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         interval_ff  <= INTERVAL_RST;
         spb_ff       <= BUCKET_RST;
         sum_ff       <= '0;
         ss_ff        <= '0;
         ups_ff       <= '0;
         all_ff       <= '0;
         fill_ff      <= '0;
         up_tot_ff    <= '0;
         dn_tot_ff    <= '0;
         last_str_ff  <= '0;
         last_up_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         interval_ff  <= interval_in;
         spb_ff       <= spb_in;
         sum_ff       <= sum_in;
         ss_ff        <= ss_in;
         ups_ff       <= ups_in;
         all_ff       <= all_in;
         fill_ff      <= fill_in;
         up_tot_ff    <= up_tot_in;
         dn_tot_ff    <= dn_tot_in;
         last_str_ff  <= last_str_in;
         last_up_ff   <= last_up_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      avg_ff      <= avg_in;
      pct_ff      <= pct_in;
      ent_ff      <= ent_in;
      closed_ff   <= closed_in;
      in_range_ff <= in_range_in;
      if (load_rsp) begin
         rsp_recent_strength    <= last_str_ff;
         rsp_recent_link_up     <= last_up_ff;
         rsp_up_seconds         <= up_tot_ff;
         rsp_down_seconds       <= dn_tot_ff;
         rsp_slot_now           <= fill_x[SLOT_W-1:0];
         rsp_bucket_closed      <= closed_ff;
         rsp_entry_valid        <= ent_ff.valid;
         rsp_entry_avg_strength <= ent_ff.avg;
         rsp_entry_up_percent   <= ent_ff.pct;
         rsp_entry_count        <= ent_ff.cnt;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- rtl/lqbs_checker.sv -----
// ----------------------------------------------------------------------------
// Link quality bucket statistics: port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lqbs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_up_seconds,
   input logic        rsp_bucket_closed,
   input logic        rsp_entry_valid,
   input logic [6:0]  rsp_entry_up_percent
);

   `LQ_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_up_seconds), "stalled response beat changed")
   `LQ_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "response valid after reset")
   `LQ_ASSERT_ALWAYS(a_wipe_stall, clock, reset |=> req_stall, "request taken during history wipe")
   `LQ_ASSERT(a_closed_valid, clock, reset, rsp_valid && rsp_bucket_closed |-> rsp_entry_valid, "closed bucket entry not valid")
   `LQ_ASSERT(a_pct_range, clock, reset, rsp_valid |-> rsp_entry_up_percent <= 7'd100, "percentage above 100")

endmodule

bind link_quality_bucket_stats_unit lqbs_checker u_checker (
   .clock                (clock),
   .reset                (reset),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_up_seconds       (rsp_up_seconds),
   .rsp_bucket_closed    (rsp_bucket_closed),
   .rsp_entry_valid      (rsp_entry_valid),
   .rsp_entry_up_percent (rsp_entry_up_percent)
);

`default_nettype wire
